@@ design/bwd8_pkg.sv @@
// Shared types, constants and register map of the decimate-by-eight Butterworth filter.
`timescale 1ns / 1ps

package bwd8_pkg;

    localparam int NUM_STAGES     = 3;
    localparam int NUM_BIQUADS    = 2 * NUM_STAGES;
    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_BITS      = 24;
    localparam int COEF_FRAC_BITS = 22;

    localparam int BQ_IDX_W    = (NUM_BIQUADS > 1) ? $clog2(NUM_BIQUADS) : 1;
    localparam int STAGE_IDX_W = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;

    // x + 2*x1 + x2 needs two more bits than a sample.
    localparam int FF_W   = SAMPLE_BITS + 2;
    localparam int PROD_W = COEF_BITS + FF_W;
    localparam int ACC_W  = PROD_W + 2;

    localparam logic signed [ACC_W-1:0] ACC_RND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] ACC_SAT_HI   =
        ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] ACC_SAT_LO   = -ACC_SAT_HI - ACC_W'(1);

    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SECTION_A_B0  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SECTION_A_A1  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SECTION_A_A2  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SECTION_B_B0  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SECTION_B_A1  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SECTION_B_A2  = 3'd6;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;

    localparam logic [1:0] CHANNEL_COUNT_RESET = 2'd2;
    localparam coef_t      SECTION_A_B0_RESET  = 24'sd1283876;
    localparam coef_t      SECTION_A_A1_RESET  = -24'sd952107;
    localparam coef_t      SECTION_A_A2_RESET  = 24'sd1893309;
    localparam coef_t      SECTION_B_B0_RESET  = 24'sd925264;
    localparam coef_t      SECTION_B_A1_RESET  = -24'sd686188;
    localparam coef_t      SECTION_B_A2_RESET  = 24'sd191680;

    typedef struct packed {
        logic [1:0] channel_count;
        coef_t      section_a_b0;
        coef_t      section_a_a1;
        coef_t      section_a_a2;
        coef_t      section_b_b0;
        coef_t      section_b_a1;
        coef_t      section_b_a2;
    } cfg_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_B,
        OP_MUL_A1,
        OP_MUL_A2,
        OP_ACC,
        OP_UPDATE
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic [BQ_IDX_W-1:0] bq_idx;
        logic                emit;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

@@ design/butterworth_decimate_by_eight_top.sv @@
// Each biquad runs its five steps on the single shared 24x26 multiplier; an accepted
// input runs through the first k stages only, k being set by the decimation phases,
// and a result is kept only when the last stage is on its kept phase.
// The output register frees the input side.
// Reset (aresetn, synchronous, active low) clears filter history, phases and the
// output valid, and loads the 0.225 cutoff coefficient set and a channel count of two.
`timescale 1ns / 1ps

module butterworth_decimate_by_eight_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [23:0] sample_left, [47:24] sample_right
    input  logic [2*bwd8_pkg::SAMPLE_BITS-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [23:0] decimated_sample
    output logic [bwd8_pkg::SAMPLE_BITS-1:0]    m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bwd8_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import bwd8_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    bwd8_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bwd8_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    bwd8_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ design/bwd8_regs.sv @@
// APB configuration registers: channel count and the two biquad coefficient sets.
`timescale 1ns / 1ps

module bwd8_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bwd8_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output bwd8_pkg::cfg_t                 cfg
);
    import bwd8_pkg::*;

    cfg_t                 cfg_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.channel_count <= CHANNEL_COUNT_RESET;
            cfg_reg.section_a_b0  <= SECTION_A_B0_RESET;
            cfg_reg.section_a_a1  <= SECTION_A_A1_RESET;
            cfg_reg.section_a_a2  <= SECTION_A_A2_RESET;
            cfg_reg.section_b_b0  <= SECTION_B_B0_RESET;
            cfg_reg.section_b_a1  <= SECTION_B_A1_RESET;
            cfg_reg.section_b_a2  <= SECTION_B_A2_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_CHANNEL_COUNT: cfg_reg.channel_count <= pwdata[1:0];
                REG_SECTION_A_B0:  cfg_reg.section_a_b0  <= pwdata[COEF_BITS-1:0];
                REG_SECTION_A_A1:  cfg_reg.section_a_a1  <= pwdata[COEF_BITS-1:0];
                REG_SECTION_A_A2:  cfg_reg.section_a_a2  <= pwdata[COEF_BITS-1:0];
                REG_SECTION_B_B0:  cfg_reg.section_b_b0  <= pwdata[COEF_BITS-1:0];
                REG_SECTION_B_A1:  cfg_reg.section_b_a1  <= pwdata[COEF_BITS-1:0];
                REG_SECTION_B_A2:  cfg_reg.section_b_a2  <= pwdata[COEF_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_CHANNEL_COUNT: prdata = {30'd0, cfg_reg.channel_count};
            REG_SECTION_A_B0:  prdata = 32'(signed'(cfg_reg.section_a_b0));
            REG_SECTION_A_A1:  prdata = 32'(signed'(cfg_reg.section_a_a1));
            REG_SECTION_A_A2:  prdata = 32'(signed'(cfg_reg.section_a_a2));
            REG_SECTION_B_B0:  prdata = 32'(signed'(cfg_reg.section_b_b0));
            REG_SECTION_B_A1:  prdata = 32'(signed'(cfg_reg.section_b_a1));
            REG_SECTION_B_A2:  prdata = 32'(signed'(cfg_reg.section_b_a2));
            default:           prdata = 32'd0;
        endcase
    end

endmodule

@@ design/bwd8_datapath.sv @@
// Datapath: mono mix, shared multiplier and accumulator, biquad history and output register.
`timescale 1ns / 1ps

module bwd8_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  bwd8_pkg::cfg_t                      cfg,
    input  bwd8_pkg::dp_cmd_t                   cmd,
    output bwd8_pkg::dp_status_t                status,
    input  logic [2*bwd8_pkg::SAMPLE_BITS-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bwd8_pkg::SAMPLE_BITS-1:0]    m_tdata
);
    import bwd8_pkg::*;

    sample_t x1_reg [NUM_BIQUADS];
    sample_t x2_reg [NUM_BIQUADS];
    sample_t y1_reg [NUM_BIQUADS];
    sample_t y2_reg [NUM_BIQUADS];

    sample_t                   x_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    sample_t                   out_reg;
    logic                      m_tvalid_reg;

    sample_t                   left;
    sample_t                   right;
    logic signed [SAMPLE_BITS:0] pair_sum;
    sample_t                   mono;
    logic                      sec_b;
    coef_t                     b0;
    coef_t                     a1;
    coef_t                     a2;
    logic signed [FF_W-1:0]    ff;
    coef_t                     mul_a;
    logic signed [FF_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [ACC_W-1:0]   rnd;
    logic signed [ACC_W-1:0]   quot;
    sample_t                   y;

    assign left     = s_tdata[SAMPLE_BITS-1:0];
    assign right    = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign pair_sum = (SAMPLE_BITS+1)'(left) + (SAMPLE_BITS+1)'(right);
    // Dropping the low bit of the sum floors toward minus infinity.
    assign mono     = (cfg.channel_count == 2'd1) ? left : pair_sum[SAMPLE_BITS:1];

    always_comb begin
        sec_b = cmd.bq_idx[0];
        b0    = sec_b ? signed'(cfg.section_b_b0) : signed'(cfg.section_a_b0);
        a1    = sec_b ? signed'(cfg.section_b_a1) : signed'(cfg.section_a_a1);
        a2    = sec_b ? signed'(cfg.section_b_a2) : signed'(cfg.section_a_a2);
        // The feedforward taps share b0, so they fold into one product.
        ff    = FF_W'(x_reg) + (FF_W'(x1_reg[cmd.bq_idx]) <<< 1) + FF_W'(x2_reg[cmd.bq_idx]);
        case (cmd.op)
            OP_MUL_B: begin
                mul_a = b0;
                mul_b = ff;
            end
            OP_MUL_A1: begin
                mul_a = a1;
                mul_b = FF_W'(y1_reg[cmd.bq_idx]);
            end
            OP_MUL_A2: begin
                mul_a = a2;
                mul_b = FF_W'(y2_reg[cmd.bq_idx]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;

        rnd  = acc_reg + ACC_RND_HALF;
        quot = rnd >>> COEF_FRAC_BITS;
        if (quot > ACC_SAT_HI) begin
            y = ACC_SAT_HI[SAMPLE_BITS-1:0];
        end else if (quot < ACC_SAT_LO) begin
            y = ACC_SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            y = quot[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD:   x_reg <= mono;
            OP_UPDATE: x_reg <= y;
            default: begin
            end
        endcase
        case (cmd.op)
            OP_MUL_B, OP_MUL_A1, OP_MUL_A2: prod_reg <= prod_next;
            default: begin
            end
        endcase
        case (cmd.op)
            OP_MUL_A1:         acc_reg <= ACC_W'(prod_reg);
            OP_MUL_A2, OP_ACC: acc_reg <= acc_reg - ACC_W'(prod_reg);
            default: begin
            end
        endcase
        if (cmd.op == OP_UPDATE && cmd.emit) begin
            out_reg <= y;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_BIQUADS; i++) begin
                x1_reg[i] <= '0;
                x2_reg[i] <= '0;
                y1_reg[i] <= '0;
                y2_reg[i] <= '0;
            end
        end else if (cmd.op == OP_UPDATE) begin
            x2_reg[cmd.bq_idx] <= x1_reg[cmd.bq_idx];
            x1_reg[cmd.bq_idx] <= x_reg;
            y2_reg[cmd.bq_idx] <= y1_reg[cmd.bq_idx];
            y1_reg[cmd.bq_idx] <= y;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.op == OP_UPDATE && cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign status.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = out_reg;

endmodule

@@ design/bwd8_ctrl.sv @@
// Controller: sequences the five steps of each biquad and tracks the decimation phases.
`timescale 1ns / 1ps

module bwd8_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output bwd8_pkg::dp_cmd_t     cmd,
    input  bwd8_pkg::dp_status_t  status
);
    import bwd8_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_MUL_B  = 6'b000010,
        ST_MUL_A1 = 6'b000100,
        ST_MUL_A2 = 6'b001000,
        ST_ACC    = 6'b010000,
        ST_UPDATE = 6'b100000
    } ctrl_state_t;

    ctrl_state_t             state_reg;
    ctrl_state_t             state_next;
    logic [BQ_IDX_W-1:0]     bq_idx_reg;
    logic [BQ_IDX_W-1:0]     bq_idx_next;
    logic                    phase_reg  [NUM_STAGES];
    logic                    phase_next [NUM_STAGES];

    logic [STAGE_IDX_W-1:0]  stage;
    logic                    last_bq;
    logic                    emit;
    logic                    stall;
    logic                    accept;

    assign stage   = STAGE_IDX_W'(bq_idx_reg >> 1);
    assign last_bq = (bq_idx_reg == BQ_IDX_W'(NUM_BIQUADS - 1));
    assign emit    = last_bq && phase_reg[stage];
    assign stall   = emit && !status.out_free;
    assign accept  = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        bq_idx_next = bq_idx_reg;
        for (int i = 0; i < NUM_STAGES; i++) begin
            phase_next[i] = phase_reg[i];
        end
        cmd.op     = OP_NONE;
        cmd.bq_idx = bq_idx_reg;
        cmd.emit   = emit;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.op      = OP_LOAD;
                    bq_idx_next = '0;
                    state_next  = ST_MUL_B;
                end
            end
            ST_MUL_B: begin
                cmd.op     = OP_MUL_B;
                state_next = ST_MUL_A1;
            end
            ST_MUL_A1: begin
                cmd.op     = OP_MUL_A1;
                state_next = ST_MUL_A2;
            end
            ST_MUL_A2: begin
                cmd.op     = OP_MUL_A2;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.op     = OP_ACC;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (!stall) begin
                    cmd.op = OP_UPDATE;
                    // A stage's output is kept on every second transaction only.
                    if (bq_idx_reg[0]) begin
                        phase_next[stage] = !phase_reg[stage];
                        if (!phase_reg[stage] || last_bq) begin
                            state_next = ST_IDLE;
                        end else begin
                            bq_idx_next = bq_idx_reg + BQ_IDX_W'(1);
                            state_next  = ST_MUL_B;
                        end
                    end else begin
                        bq_idx_next = bq_idx_reg + BQ_IDX_W'(1);
                        state_next  = ST_MUL_B;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            bq_idx_reg <= '0;
            for (int i = 0; i < NUM_STAGES; i++) begin
                phase_reg[i] <= 1'b0;
            end
        end else begin
            state_reg  <= state_next;
            bq_idx_reg <= bq_idx_next;
            for (int i = 0; i < NUM_STAGES; i++) begin
                phase_reg[i] <= phase_next[i];
            end
        end
    end

    a_emit_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_UPDATE && cmd.emit) |-> last_bq)
        else $error("result emitted before the last biquad");

    a_emit_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_UPDATE && cmd.emit) |-> status.out_free)
        else $error("result emitted while the output register is occupied");

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (bq_idx_reg < BQ_IDX_W'(NUM_BIQUADS)))
        else $error("biquad index out of range");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_MUL_B && bq_idx_reg == '0))
        else $error("accepted transaction did not start at the first biquad");

endmodule
